@@ hw/rtl/magic_frame_deframer_with_passthrough_unit_assert.svh @@
// Assertion macros shared by the deframer modules.
// Each expects signals named clk and rst in the scope where it is used.
`ifndef MAGIC_FRAME_DEFRAMER_WITH_PASSTHROUGH_UNIT_ASSERT_SVH
`define MAGIC_FRAME_DEFRAMER_WITH_PASSTHROUGH_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// The consequent must hold in the cycle after the antecedent.
`define MFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

@@ hw/rtl/mfd_pkg.sv @@
package mfd_pkg;

  localparam int PAYLOAD_DEPTH = 128;
  localparam int MAGIC_LENGTH  = 6;
  localparam int PAY_AW        = $clog2(PAYLOAD_DEPTH);

  localparam logic [7:0] MAGIC_WORD [8] = '{8'h49, 8'h4D, 8'h50, 8'h52,
                                            8'h4F, 8'h56, 8'h00, 8'h00};

  localparam logic [7:0] RESET_VERSION  = 8'h01;
  localparam logic [7:0] RESET_TYPE     = 8'h03;
  localparam logic [7:0] RESET_MAX_LEN  = 8'd128;

  typedef enum logic [2:0] {
    KIND_CONSOLE = 3'd0,
    KIND_ACCEPT  = 3'd1,
    KIND_BAD_SUM = 3'd2,
    KIND_SHORT   = 3'd3,
    KIND_PAYLOAD = 3'd4
  } kind_t;

  typedef enum logic {
    OP_SERIAL = 1'b0,
    OP_READ   = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    REG_VERSION = 2'd0,
    REG_TYPE    = 2'd1,
    REG_MAX_LEN = 2'd2
  } reg_index_t;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_MAGIC  = 5'b00010,
    PH_HEADER = 5'b00100,
    PH_DATA   = 5'b01000,
    PH_CHECK  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] serial_byte;
    logic [6:0] payload_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] byte_value;
    logic [7:0] command_code;
    logic [6:0] usable_length;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] expected_version;
    logic [7:0] expected_type;
    logic [7:0] max_data_length;
  } cfg_regs_t;

  // Results that one accepted item causes: released magic bytes, then
  // an optional closing result.
  typedef struct packed {
    logic [2:0] rel_count;
    logic       final_present;
    kind_t      final_kind;
    logic [7:0] final_byte;
    logic       from_mem;
    logic [7:0] command;
    logic [6:0] usable;
  } desc_t;

endpackage

@@ hw/rtl/mfd_payload_store.sv @@
module mfd_payload_store
  import mfd_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [PAY_AW-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [PAY_AW-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [PAYLOAD_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data is held until the next read so a stalled result keeps it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/mfd_parser.sv @@
`include "magic_frame_deframer_with_passthrough_unit_assert.svh"

module mfd_parser
  import mfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  in_item_t          item,
  input  cfg_regs_t         cfg,
  output desc_t             desc,
  output logic              desc_valid,
  output logic              wr_en,
  output logic [PAY_AW-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output logic              rd_en,
  output logic [PAY_AW-1:0] rd_addr
);

  phase_t     phase, phase_next;
  logic [2:0] matched_count, matched_count_next;
  logic [1:0] header_count, header_count_next;
  logic [7:0] header_version, header_version_next;
  logic [7:0] header_type, header_type_next;
  logic [7:0] declared_length, declared_length_next;
  logic [7:0] received_count, received_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] cmd_byte, cmd_byte_next;
  logic [7:0] inner_len, inner_len_next;

  logic [7:0] b;
  logic [7:0] sum_plus;
  logic [3:0] matched_inc;
  logic [7:0] recv_inc;
  logic [7:0] read_idx;
  logic [7:0] avail;
  logic [7:0] use_len;
  logic       do_hunt;

  assign b           = item.serial_byte;
  assign sum_plus    = running_sum + b;
  assign matched_inc = {1'b0, matched_count} + 4'd1;
  assign recv_inc    = received_count + 8'd1;
  assign read_idx    = {1'b0, item.payload_index} + 8'd2;
  assign avail       = declared_length - 8'd2;
  assign use_len     = (inner_len < avail) ? inner_len : avail;

  assign rd_en   = accept && (item.opcode == OP_READ);
  assign rd_addr = read_idx[PAY_AW-1:0];

  always_comb begin
    phase_next           = phase;
    matched_count_next   = matched_count;
    header_count_next    = header_count;
    header_version_next  = header_version;
    header_type_next     = header_type;
    declared_length_next = declared_length;
    received_count_next  = received_count;
    running_sum_next     = running_sum;
    cmd_byte_next        = cmd_byte;
    inner_len_next       = inner_len;
    desc                 = '0;
    desc.final_kind      = KIND_CONSOLE;
    wr_en                = 1'b0;
    wr_addr              = received_count[PAY_AW-1:0];
    wr_data              = b;
    do_hunt              = 1'b0;

    if (item.opcode == OP_READ) begin
      desc.final_present = 1'b1;
      desc.final_kind    = KIND_PAYLOAD;
      desc.from_mem      = (read_idx < 8'(PAYLOAD_DEPTH));
    end else begin
      unique case (phase)
        PH_MAGIC: begin
          if (b == MAGIC_WORD[matched_count]) begin
            matched_count_next = matched_inc[2:0];
            running_sum_next   = sum_plus;
            if (matched_inc >= 4'(MAGIC_LENGTH)) begin
              header_count_next = 2'd0;
              phase_next        = PH_HEADER;
            end
          end else begin
            // Release the held prefix, then try the failing byte afresh.
            desc.rel_count     = matched_count;
            matched_count_next = 3'd0;
            phase_next         = PH_IDLE;
            do_hunt            = 1'b1;
          end
        end
        PH_HEADER: begin
          running_sum_next = sum_plus;
          if (header_count == 2'd0) begin
            header_version_next = b;
            header_count_next   = 2'd1;
          end else if (header_count == 2'd1) begin
            header_type_next  = b;
            header_count_next = 2'd2;
          end else begin
            header_count_next = 2'd0;
            if (header_version != cfg.expected_version ||
                header_type != cfg.expected_type ||
                b > cfg.max_data_length) begin
              phase_next = PH_IDLE;
            end else begin
              declared_length_next = b;
              received_count_next  = 8'd0;
              phase_next           = (b == 8'd0) ? PH_CHECK : PH_DATA;
            end
          end
        end
        PH_DATA: begin
          wr_en               = (received_count < 8'(PAYLOAD_DEPTH));
          received_count_next = recv_inc;
          running_sum_next    = sum_plus;
          // The first two data bytes are also kept in registers for the
          // frame report.
          if (received_count == 8'd0) begin
            cmd_byte_next = b;
          end
          if (received_count == 8'd1) begin
            inner_len_next = b;
          end
          if (recv_inc == declared_length) begin
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase_next         = PH_IDLE;
          desc.final_present = 1'b1;
          if (b != running_sum) begin
            desc.final_kind = KIND_BAD_SUM;
          end else if (declared_length < 8'd2) begin
            desc.final_kind = KIND_SHORT;
          end else begin
            desc.final_kind = KIND_ACCEPT;
            desc.command    = cmd_byte;
            desc.usable     = use_len[7] ? 7'd127 : use_len[6:0];
          end
        end
        default: begin
          phase_next = PH_IDLE;
          do_hunt    = 1'b1;
        end
      endcase

      if (do_hunt) begin
        if (b == MAGIC_WORD[0]) begin
          matched_count_next = 3'd1;
          running_sum_next   = b;
          if (MAGIC_LENGTH <= 1) begin
            header_count_next = 2'd0;
            phase_next        = PH_HEADER;
          end else begin
            phase_next = PH_MAGIC;
          end
        end else begin
          desc.final_present = 1'b1;
          desc.final_kind    = KIND_CONSOLE;
          desc.final_byte    = b;
        end
      end
    end
  end

  assign desc_valid = accept && (desc.final_present || (desc.rel_count != 3'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      matched_count   <= 3'd0;
      header_count    <= 2'd0;
      header_version  <= 8'd0;
      header_type     <= 8'd0;
      declared_length <= 8'd0;
      received_count  <= 8'd0;
      running_sum     <= 8'd0;
    end else if (accept) begin
      phase           <= phase_next;
      matched_count   <= matched_count_next;
      header_count    <= header_count_next;
      header_version  <= header_version_next;
      header_type     <= header_type_next;
      declared_length <= declared_length_next;
      received_count  <= received_count_next;
      running_sum     <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_byte  <= cmd_byte_next;
      inner_len <= inner_len_next;
    end
  end

  `MFD_ASSERT_SAME(a_data_count, phase == PH_DATA, received_count < declared_length)
  `MFD_ASSERT_SAME(a_magic_count, phase == PH_MAGIC,
                   matched_count != 3'd0 && {1'b0, matched_count} < 4'(MAGIC_LENGTH))
  `MFD_ASSERT_SAME(a_header_count, phase == PH_HEADER, header_count != 2'd3)

endmodule

@@ hw/rtl/mfd_emitter.sv @@
`include "magic_frame_deframer_with_passthrough_unit_assert.svh"

module mfd_emitter
  import mfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  desc_t      desc_in,
  input  logic [7:0] mem_data,
  output logic       free,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item
);

  logic       busy;
  desc_t      desc;
  logic [2:0] pos;
  logic [3:0] total;
  logic [3:0] pos_inc;
  logic       is_last;
  logic       out_fire;
  logic       releasing;

  assign total     = {1'b0, desc.rel_count} + {3'b000, desc.final_present};
  assign pos_inc   = {1'b0, pos} + 4'd1;
  assign is_last   = (pos_inc == total);
  assign out_fire  = out_valid && out_ready;
  assign releasing = (pos < desc.rel_count);
  assign out_valid = busy;
  assign free      = !busy || (out_ready && is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= 3'd0;
    end else if (load) begin
      busy <= 1'b1;
      pos  <= 3'd0;
    end else if (out_fire) begin
      if (is_last) begin
        busy <= 1'b0;
        pos  <= 3'd0;
      end else begin
        pos <= pos_inc[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc <= desc_in;
    end
  end

  always_comb begin
    out_item      = '0;
    out_item.last = is_last;
    if (releasing) begin
      out_item.kind       = KIND_CONSOLE;
      out_item.byte_value = MAGIC_WORD[pos];
    end else begin
      out_item.kind          = desc.final_kind;
      out_item.byte_value    = desc.from_mem ? mem_data : desc.final_byte;
      out_item.command_code  = desc.command;
      out_item.usable_length = desc.usable;
    end
  end

  `MFD_ASSERT_SAME(a_pos_in_range, busy, {1'b0, pos} < total)
  `MFD_ASSERT_SAME(a_load_not_empty, load,
                   desc_in.final_present || desc_in.rel_count != 3'd0)
  `MFD_ASSERT_NEXT(a_more_follow, out_fire && !is_last, busy)

endmodule

@@ hw/rtl/magic_frame_deframer_with_passthrough_unit.sv @@
// Channel   Signals                          Moves
// in        in_valid, in_ready, in_item     one serial byte or payload read per item
// out       out_valid, out_ready, out_item  one result per item
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data  register write, always ready
//
// An item that causes one result or none is taken every cycle while out_ready is
// high. An item that causes several results holds the input while the result
// stage sends them out; a failed magic match releases up to MAGIC_LENGTH results.
// Payload reads go through the store's registered read port into the result stage.
// Reset clears the parser and result stage; the payload store is not cleared.
// A stalled output holds the result stage and drops in_ready once it is full.
module magic_frame_deframer_with_passthrough_unit
  import mfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_regs_t         cfg;
  logic              accept;
  desc_t             desc;
  logic              desc_valid;
  logic              wr_en;
  logic [PAY_AW-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [PAY_AW-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              free;

  assign cfg_ready = 1'b1;
  assign in_ready  = free;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_version <= RESET_VERSION;
      cfg.expected_type    <= RESET_TYPE;
      cfg.max_data_length  <= RESET_MAX_LEN;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_VERSION: cfg.expected_version <= cfg_data;
        REG_TYPE:    cfg.expected_type    <= cfg_data;
        REG_MAX_LEN: cfg.max_data_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  mfd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (in_item),
    .cfg        (cfg),
    .desc       (desc),
    .desc_valid (desc_valid),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr)
  );

  mfd_payload_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mfd_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .load      (desc_valid),
    .desc_in   (desc),
    .mem_data  (rd_data),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
